// File: rtl/core/msvg_pkg.sv
// ----------------------------------------------------------------------------
// msvg_pkg
// Shared constants, types and helper functions of the max-slope volume
// gradient block.
// ----------------------------------------------------------------------------
package msvg_pkg;

  // Volume geometry and sample format
  localparam int MAX_DIM    = 128;
  localparam int MIN_DIM    = 3;
  localparam int VOXEL_BITS = 16;
  localparam int GRAD_W     = VOXEL_BITS + 1;
  localparam int POS_W      = $clog2(MAX_DIM);
  localparam int SIZE_W     = POS_W + 1;

  // Plane store: one word per (y, z) holds both planes of the ring
  localparam int ADDR_W = 2 * POS_W;
  localparam int WORD_W = 2 * VOXEL_BITS;

  // Configuration port
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W     = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;
  localparam logic [CFG_W-1:0]     CFG_RESET  = CFG_W'(128);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = CFG_IDX_W'(2);

  // Output queue
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  typedef logic signed [VOXEL_BITS-1:0] voxel_t;
  typedef logic signed [GRAD_W-1:0]     grad_t;
  typedef logic [POS_W-1:0]             pos_t;
  typedef logic [SIZE_W-1:0]            dim_t;

  // One result beat
  typedef struct packed {
    pos_t  at_x;
    pos_t  at_y;
    pos_t  at_z;
    grad_t grad_x;
    grad_t grad_y;
    grad_t grad_z;
    logic  run_end;
  } res_t;

  // Voxel in the memory read stage
  typedef struct packed {
    pos_t   px;
    pos_t   py;
    pos_t   pz;
    voxel_t cur;
    logic   first_zero;
    logic   grad;
    logic   last_zero;
    logic   inner;
  } s1_t;

  // Voxel in the selection stage, with backward and forward differences
  typedef struct packed {
    pos_t  px;
    pos_t  py;
    pos_t  pz;
    logic  first_zero;
    logic  grad;
    logic  last_zero;
    logic  inner;
    grad_t bx;
    grad_t fx;
    grad_t by;
    grad_t fy;
    grad_t bz;
    grad_t fz;
  } s2_t;

  // Register value clamped to the supported range of sizes
  function automatic dim_t eff_size(logic [CFG_W-1:0] r);
    logic [CMP_W-1:0] v;
    v = CMP_W'(r);
    if (v < CMP_W'(MIN_DIM)) begin
      return SIZE_W'(MIN_DIM);
    end else if (v > CMP_W'(MAX_DIM)) begin
      return SIZE_W'(MAX_DIM);
    end
    return SIZE_W'(v);
  endfunction

  // Larger magnitude wins; forward difference on a tie
  function automatic grad_t pick(grad_t back, grad_t fwd);
    logic [GRAD_W-1:0] ab;
    logic [GRAD_W-1:0] af;
    ab = back[GRAD_W-1] ? GRAD_W'(-back) : GRAD_W'(back);
    af = fwd[GRAD_W-1]  ? GRAD_W'(-fwd)  : GRAD_W'(fwd);
    return (ab > af) ? back : fwd;
  endfunction

endpackage

// File: rtl/core/msvg_if.sv
// ----------------------------------------------------------------------------
// msvg_in_if / msvg_out_if
// Valid/ready channels of the gradient block: voxels in, results out.
// ----------------------------------------------------------------------------
interface msvg_in_if;
  import msvg_pkg::*;

  logic   valid;
  logic   ready;
  voxel_t voxel;

  modport source (output valid, output voxel, input ready);
  modport sink   (input valid, input voxel, output ready);
endinterface

interface msvg_out_if;
  import msvg_pkg::*;

  logic  valid;
  logic  ready;
  pos_t  at_x;
  pos_t  at_y;
  pos_t  at_z;
  grad_t grad_x;
  grad_t grad_y;
  grad_t grad_z;
  logic  run_end;

  modport source (output valid, output at_x, output at_y, output at_z,
                  output grad_x, output grad_y, output grad_z, output run_end,
                  input ready);
  modport sink   (input valid, input at_x, input at_y, input at_z,
                  input grad_x, input grad_y, input grad_z, input run_end,
                  output ready);
endinterface

// File: rtl/core/msvg_ram.sv
// ----------------------------------------------------------------------------
// msvg_ram
// Synchronous RAM, one write port and two read ports, registered read data.
// ----------------------------------------------------------------------------
module msvg_ram #(
  parameter int ADDR_W = 14,
  parameter int DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);
  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] ram_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ram_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= ram_q[raddr_a_i];
      rdata_b_o <= ram_q[raddr_b_i];
    end
  end

endmodule

// File: rtl/core/msvg_sel.sv
// ----------------------------------------------------------------------------
// msvg_sel
// Per-axis slope selection and result formation for one voxel: zero or one
// gradient beat, optionally followed by the voxel's own border beat.
// ----------------------------------------------------------------------------
module msvg_sel (
  input  msvg_pkg::s2_t  s2_i,
  output msvg_pkg::res_t res0_o,
  output msvg_pkg::res_t res1_o,
  output logic [1:0]     cnt_o
);
  import msvg_pkg::*;

  grad_t gx;
  grad_t gy;
  grad_t gz;
  pos_t  cx;
  res_t  own;

  // Interior voxels only; every border voxel reports zero
  assign gx = s2_i.inner ? pick(s2_i.bx, s2_i.fx) : '0;
  assign gy = s2_i.inner ? pick(s2_i.by, s2_i.fy) : '0;
  assign gz = s2_i.inner ? pick(s2_i.bz, s2_i.fz) : '0;
  assign cx = s2_i.px - POS_W'(1);

  // Border beat of the incoming voxel itself
  always_comb begin
    own.at_x    = s2_i.px;
    own.at_y    = s2_i.py;
    own.at_z    = s2_i.pz;
    own.grad_x  = '0;
    own.grad_y  = '0;
    own.grad_z  = '0;
    own.run_end = 1'b1;
  end

  always_comb begin
    res0_o = own;
    res1_o = own;
    cnt_o  = 2'd0;
    if (s2_i.first_zero) begin
      cnt_o = 2'd1;
    end else if (s2_i.grad) begin
      res0_o.at_x    = cx;
      res0_o.grad_x  = gx;
      res0_o.grad_y  = gy;
      res0_o.grad_z  = gz;
      res0_o.run_end = ~s2_i.last_zero;
      cnt_o          = s2_i.last_zero ? 2'd2 : 2'd1;
    end
  end

endmodule

// File: rtl/core/msvg_ofifo.sv
// ----------------------------------------------------------------------------
// msvg_ofifo
// Result queue: takes up to two beats per cycle, hands out one.
// ----------------------------------------------------------------------------
module msvg_ofifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [1:0]                 push_n_i,
  input  msvg_pkg::res_t             res0_i,
  input  msvg_pkg::res_t             res1_i,
  input  logic                       ready_i,
  output logic                       valid_o,
  output msvg_pkg::res_t             data_o,
  output logic [msvg_pkg::OQ_CNT_W-1:0] count_o
);
  import msvg_pkg::*;

  res_t                ent_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wptr_q, wptr_d;
  logic [OQ_PTR_W-1:0] rptr_q, rptr_d;
  logic [OQ_CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]          n_in;
  logic                pop;

  assign n_in    = push_i ? push_n_i : 2'd0;
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o & ready_i;
  assign data_o  = ent_q[rptr_q];
  assign count_o = cnt_q;

  // Pointer and fill bookkeeping
  always_comb begin
    wptr_d = wptr_q + OQ_PTR_W'(n_in);
    rptr_d = rptr_q + OQ_PTR_W'(pop);
    cnt_d  = cnt_q + OQ_CNT_W'(n_in) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage, one or two beats written per cycle
  always_ff @(posedge clk_i) begin
    if (n_in != 2'd0) begin
      ent_q[wptr_q] <= res0_i;
    end
    if (n_in == 2'd2) begin
      ent_q[wptr_q + OQ_PTR_W'(1)] <= res1_i;
    end
  end

endmodule

// File: rtl/core/max_slope_volume_gradient.sv
// ----------------------------------------------------------------------------
// max_slope_volume_gradient
// Streaming three-axis max-slope gradient over a raster-ordered 3-D volume.
// ----------------------------------------------------------------------------
// Usage:
//   vox_i takes one voxel beat per cycle while vox_i.ready is high (z
//   fastest, x slowest). res_o gives result beats in raster order, save the
//   last two planes, whose beats interleave per (y, z); each is tagged with
//   its coordinates; run_end marks the last beat caused by a voxel (plane 0
//   gives one, plane 1 none, later planes one, the last plane two). Results
//   pass the ring read register, the difference register and the queue.
//   Throughput is one voxel per cycle while the queue has room, set by the
//   two plane stores, each written once and read at two addresses per cycle;
//   on the last plane the single output beat per cycle limits it, as each
//   voxel there gives two beats. Config writes (size_x, size_y, size_z)
//   restart the volume at position zero; the user must make them only while
//   the block is idle, and the block itself does not enforce this.
//   Reset: sizes go to 128, position to zero; the plane store contents are
//   undefined and need no clearing: no unwritten entry reaches a result.
//   Stall: results wait in an 8-beat queue; vox_i.ready drops once the queue
//   cannot hold two beats for every voxel still in flight.
// ----------------------------------------------------------------------------
module max_slope_volume_gradient (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  msvg_in_if.sink                        vox_i,
  msvg_out_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [msvg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [msvg_pkg::CFG_W-1:0]     cfg_data_i
);
  import msvg_pkg::*;

  logic [CFG_W-1:0] size_x_q, size_y_q, size_z_q;
  dim_t             sx, sy, sz;
  pos_t             px_q, py_q, pz_q;
  pos_t             px_d, py_d, pz_d;
  logic             cfg_hit;
  logic             accept;
  logic             z_end, y_end, x_end;

  s1_t              s1_q, s1_d;
  logic             v1_q;
  s2_t              s2_q, s2_d;
  logic             v2_q;

  logic [ADDR_W-1:0] addr_c, addr_ym, addr_yp, addr_zp, addr_w;
  logic [WORD_W-1:0] word_c, word_ym, word_yp, word_zp, word_w;
  voxel_t            c, back_x, ym, yp, zp, c_prev_q;

  res_t                res0, res1, oq_head;
  logic [1:0]          res_cnt;
  logic [OQ_CNT_W-1:0] oq_cnt;
  logic                oq_valid;
  logic [OQ_CNT_W:0]   oq_need;

  // Configuration registers
  assign cfg_hit = cfg_we_i &
                   ((cfg_idx_i == REG_SIZE_X) | (cfg_idx_i == REG_SIZE_Y) |
                    (cfg_idx_i == REG_SIZE_Z));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= CFG_RESET;
      size_y_q <= CFG_RESET;
      size_z_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIZE_X: size_x_q <= cfg_data_i;
        REG_SIZE_Y: size_y_q <= cfg_data_i;
        REG_SIZE_Z: size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sx = eff_size(size_x_q);
  assign sy = eff_size(size_y_q);
  assign sz = eff_size(size_z_q);

  // Input handshake: room for two beats for each voxel in flight
  assign oq_need = (OQ_CNT_W+1)'(oq_cnt) + (OQ_CNT_W+1)'({v1_q, 1'b0}) +
                   (OQ_CNT_W+1)'({v2_q, 1'b0}) + (OQ_CNT_W+1)'(2);
  assign vox_i.ready = (oq_need <= (OQ_CNT_W+1)'(OQ_DEPTH));
  assign accept      = vox_i.valid & vox_i.ready;

  // Raster position of the next voxel
  assign z_end = ({1'b0, pz_q} == sz - SIZE_W'(1));
  assign y_end = ({1'b0, py_q} == sy - SIZE_W'(1));
  assign x_end = ({1'b0, px_q} == sx - SIZE_W'(1));

  always_comb begin
    px_d = px_q;
    py_d = py_q;
    pz_d = pz_q;
    if (cfg_hit) begin
      px_d = '0;
      py_d = '0;
      pz_d = '0;
    end else if (accept) begin
      if (z_end) begin
        pz_d = '0;
        if (y_end) begin
          py_d = '0;
          px_d = x_end ? '0 : px_q + POS_W'(1);
        end else begin
          py_d = py_q + POS_W'(1);
        end
      end else begin
        pz_d = pz_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      pz_q <= '0;
    end else begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
    end
  end

  // Stage 0: classify the voxel and issue the plane reads
  always_comb begin
    s1_d.px         = px_q;
    s1_d.py         = py_q;
    s1_d.pz         = pz_q;
    s1_d.cur        = vox_i.voxel;
    s1_d.first_zero = (px_q == '0);
    s1_d.grad       = (px_q >= POS_W'(2));
    s1_d.last_zero  = (px_q >= POS_W'(2)) & x_end;
    s1_d.inner      = (py_q != '0) & ~y_end & (pz_q != '0) & ~z_end;
  end

  assign addr_c  = {py_q, pz_q};
  assign addr_ym = {py_q - POS_W'(1), pz_q};
  assign addr_yp = {py_q + POS_W'(1), pz_q};
  assign addr_zp = {py_q, pz_q + POS_W'(1)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (v1_q) begin
      s2_q <= s2_d;
    end
  end

  // Two copies of the plane ring, written alike, four read addresses
  assign addr_w = {s1_q.py, s1_q.pz};

  msvg_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (WORD_W)
  ) u_ram_a (
    .clk_i     (clk_i),
    .we_i      (v1_q),
    .waddr_i   (addr_w),
    .wdata_i   (word_w),
    .re_i      (accept),
    .raddr_a_i (addr_c),
    .raddr_b_i (addr_ym),
    .rdata_a_o (word_c),
    .rdata_b_o (word_ym)
  );

  msvg_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (WORD_W)
  ) u_ram_b (
    .clk_i     (clk_i),
    .we_i      (v1_q),
    .waddr_i   (addr_w),
    .wdata_i   (word_w),
    .re_i      (accept),
    .raddr_a_i (addr_yp),
    .raddr_b_i (addr_zp),
    .rdata_a_o (word_yp),
    .rdata_b_o (word_zp)
  );

  // Stage 1: pick plane halves; the centre plane is the one not being replaced
  assign c      = s1_q.px[0] ? word_c[VOXEL_BITS-1:0]  : word_c[WORD_W-1:VOXEL_BITS];
  assign back_x = s1_q.px[0] ? word_c[WORD_W-1:VOXEL_BITS] : word_c[VOXEL_BITS-1:0];
  assign ym     = s1_q.px[0] ? word_ym[VOXEL_BITS-1:0] : word_ym[WORD_W-1:VOXEL_BITS];
  assign yp     = s1_q.px[0] ? word_yp[VOXEL_BITS-1:0] : word_yp[WORD_W-1:VOXEL_BITS];
  assign zp     = s1_q.px[0] ? word_zp[VOXEL_BITS-1:0] : word_zp[WORD_W-1:VOXEL_BITS];

  // Write back: new voxel into its plane half, other half kept
  assign word_w = s1_q.px[0] ? {s1_q.cur, word_c[VOXEL_BITS-1:0]}
                             : {word_c[WORD_W-1:VOXEL_BITS], s1_q.cur};

  // Previous centre of this row serves as the z-1 neighbour
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      c_prev_q <= c;
    end
  end

  always_comb begin
    s2_d.px         = s1_q.px;
    s2_d.py         = s1_q.py;
    s2_d.pz         = s1_q.pz;
    s2_d.first_zero = s1_q.first_zero;
    s2_d.grad       = s1_q.grad;
    s2_d.last_zero  = s1_q.last_zero;
    s2_d.inner      = s1_q.inner;
    s2_d.bx         = GRAD_W'(c) - GRAD_W'(back_x);
    s2_d.fx         = GRAD_W'(s1_q.cur) - GRAD_W'(c);
    s2_d.by         = GRAD_W'(c) - GRAD_W'(ym);
    s2_d.fy         = GRAD_W'(yp) - GRAD_W'(c);
    s2_d.bz         = GRAD_W'(c) - GRAD_W'(c_prev_q);
    s2_d.fz         = GRAD_W'(zp) - GRAD_W'(c);
  end

  // Stage 2: slope selection and result beats
  msvg_sel u_sel (
    .s2_i   (s2_q),
    .res0_o (res0),
    .res1_o (res1),
    .cnt_o  (res_cnt)
  );

  msvg_ofifo u_ofifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (v2_q),
    .push_n_i (res_cnt),
    .res0_i   (res0),
    .res1_i   (res1),
    .ready_i  (res_o.ready),
    .valid_o  (oq_valid),
    .data_o   (oq_head),
    .count_o  (oq_cnt)
  );

  assign res_o.valid   = oq_valid;
  assign res_o.at_x    = oq_head.at_x;
  assign res_o.at_y    = oq_head.at_y;
  assign res_o.at_z    = oq_head.at_z;
  assign res_o.grad_x  = oq_head.grad_x;
  assign res_o.grad_y  = oq_head.grad_y;
  assign res_o.grad_z  = oq_head.grad_z;
  assign res_o.run_end = oq_head.run_end;

endmodule

// File: rtl/core/msvg_chk.sv
// ----------------------------------------------------------------------------
// msvg_chk
// Port-level checks on the result channel of the gradient block.
// ----------------------------------------------------------------------------
module msvg_chk (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input msvg_pkg::pos_t         at_x_i,
  input msvg_pkg::pos_t         at_y_i,
  input msvg_pkg::pos_t         at_z_i,
  input msvg_pkg::grad_t        grad_x_i,
  input msvg_pkg::grad_t        grad_y_i,
  input msvg_pkg::grad_t        grad_z_i,
  input logic                   run_end_i
);
  import msvg_pkg::*;

  // A stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({at_x_i, at_y_i, at_z_i, grad_x_i, grad_y_i, grad_z_i, run_end_i}))
    else $error("result beat changed while stalled");

  // Voxels on a low border always report zero slope
  a_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (at_x_i == '0 || at_y_i == '0 || at_z_i == '0) |->
      grad_x_i == '0 && grad_y_i == '0 && grad_z_i == '0)
    else $error("non-zero gradient on a border voxel");

  // A beat that is not the last of its voxel has its partner queued already
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !run_end_i |=> out_valid_i)
    else $error("second beat of a voxel missing");

  // Only interior-plane gradients can be followed by a second beat
  a_pair_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !run_end_i |-> at_x_i != '0)
    else $error("unterminated beat on plane zero");

endmodule

bind max_slope_volume_gradient msvg_chk u_msvg_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .at_x_i      (res_o.at_x),
  .at_y_i      (res_o.at_y),
  .at_z_i      (res_o.at_z),
  .grad_x_i    (res_o.grad_x),
  .grad_y_i    (res_o.grad_y),
  .grad_z_i    (res_o.grad_z),
  .run_end_i   (res_o.run_end)
);
